// File: design/ipudp_pkg.sv
// Shared types, constants and the ones' complement adder for the IPv4/UDP parser.
// No dependencies; every other file of the block imports this package.
package ipudp_pkg;

    localparam logic [15:0] BYTE_COUNT_MAX = 16'hffff;
    localparam logic [15:0] OFS_VER_IHL    = 16'd0;
    localparam logic [15:0] OFS_TOTAL_HI   = 16'd2;
    localparam logic [15:0] OFS_TOTAL_LO   = 16'd3;
    localparam logic [15:0] OFS_PROTOCOL   = 16'd9;
    localparam logic [15:0] OFS_SRC        = 16'd12;
    localparam logic [15:0] OFS_DST        = 16'd16;
    localparam logic [15:0] OFS_DST_END    = 16'd20;
    localparam logic [15:0] MIN_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] UDP_REL_LEN_HI = 16'd4;
    localparam logic [15:0] UDP_REL_LEN_LO = 16'd5;
    localparam logic [15:0] UDP_REL_CS_HI  = 16'd6;
    localparam logic [15:0] UDP_REL_CS_LO  = 16'd7;
    localparam logic [15:0] UDP_REL_PORTS  = 16'd4;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] CSUM_ONES      = 16'hffff;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT      = 4'd1,
        ST_NOT_V4     = 4'd2,
        ST_BAD_IHL    = 4'd3,
        ST_NOT_UDP    = 4'd4,
        ST_TOTAL_LONG = 4'd5,
        ST_IP_CSUM    = 4'd6,
        ST_UDP_LEN    = 4'd7,
        ST_UDP_CSUM   = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
    } out_item_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [6:0]  hdr_len;
        logic [3:0]  version;
        logic [7:0]  protocol;
        logic [15:0] total_len;
        logic [15:0] hdr_sum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] udp_len;
        logic [15:0] carried_csum;
        logic [15:0] udp_sum;
        logic [15:0] pseudo_sum;
        logic [31:0] ports;
        logic [7:0]  hold;
    } frame_state_t;

    // The pseudo-header sum starts from the protocol word, which every datagram carries.
    localparam frame_state_t FRAME_CLEAR = '{pseudo_sum: {8'd0, PROTO_UDP}, default: '0};

    function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: design/ipudp_accum.sv
// Per-frame state registers and the per-byte update of fields and checksums.
// Depends on ipudp_pkg.
module ipudp_accum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  ipudp_pkg::in_item_t     item,
    output ipudp_pkg::frame_state_t state_next
);
    import ipudp_pkg::*;

    frame_state_t state_reg;
    logic [15:0]  pos;
    logic [15:0]  rel;
    logic [16:0]  rel_inc;
    logic [6:0]   hlen_eff;
    logic [7:0]   b;
    logic [15:0]  word;
    logic [15:0]  len_word;

    always_comb
    begin
        state_next = state_reg;
        pos        = state_reg.byte_count;
        b          = item.frame_byte;
        hlen_eff   = (pos == OFS_VER_IHL) ? {1'b0, b[3:0], 2'b00} : state_reg.hdr_len;
        rel        = pos - {9'd0, hlen_eff};
        rel_inc    = {1'b0, rel} + 17'd1;
        word       = {state_reg.hold, b};
        len_word   = state_reg.udp_len | {8'd0, b};

        if (pos != BYTE_COUNT_MAX)
        begin
            state_next.byte_count = pos + 16'd1;

            if (pos == OFS_VER_IHL)
            begin
                state_next.version = b[7:4];
                state_next.hdr_len = hlen_eff;
            end
            else if (pos == OFS_TOTAL_HI)
            begin
                state_next.total_len = {b, 8'd0};
            end
            else if (pos == OFS_TOTAL_LO)
            begin
                state_next.total_len = state_reg.total_len | {8'd0, b};
            end
            else if (pos == OFS_PROTOCOL)
            begin
                state_next.protocol = b;
            end
            else if (pos >= OFS_SRC && pos < OFS_DST)
            begin
                state_next.src_addr = {state_reg.src_addr[23:0], b};
                if (pos[0])
                begin
                    state_next.pseudo_sum =
                        oc_add(state_reg.pseudo_sum, {state_reg.src_addr[7:0], b});
                end
            end
            else if (pos >= OFS_DST && pos < OFS_DST_END)
            begin
                state_next.dst_addr = {state_reg.dst_addr[23:0], b};
                if (pos[0])
                begin
                    state_next.pseudo_sum =
                        oc_add(state_reg.pseudo_sum, {state_reg.dst_addr[7:0], b});
                end
            end

            if (pos < {9'd0, hlen_eff})
            begin
                if (!pos[0])
                begin
                    state_next.hold = b;
                end
                else
                begin
                    state_next.hdr_sum = oc_add(state_reg.hdr_sum, word);
                end
            end
            else
            begin
                if (rel < UDP_REL_PORTS)
                begin
                    state_next.ports = {state_reg.ports[23:0], b};
                end
                else if (rel == UDP_REL_LEN_HI)
                begin
                    state_next.udp_len = {b, 8'd0};
                end
                else if (rel == UDP_REL_LEN_LO)
                begin
                    state_next.udp_len    = len_word;
                    state_next.pseudo_sum = oc_add(state_reg.pseudo_sum, len_word);
                end
                else if (rel == UDP_REL_CS_HI)
                begin
                    state_next.carried_csum = {b, 8'd0};
                end
                else if (rel == UDP_REL_CS_LO)
                begin
                    state_next.carried_csum = state_reg.carried_csum | {8'd0, b};
                end

                if (rel < UDP_HDR_BYTES)
                begin
                    if (!rel[0])
                    begin
                        state_next.hold = b;
                    end
                    else if (rel != UDP_REL_CS_LO)
                    begin
                        state_next.udp_sum = oc_add(state_reg.udp_sum, word);
                    end
                end
                else if (rel < state_reg.udp_len)
                begin
                    if (!rel[0])
                    begin
                        if (rel_inc == {1'b0, state_reg.udp_len})
                        begin
                            state_next.udp_sum = oc_add(state_reg.udp_sum, {b, 8'd0});
                        end
                        else
                        begin
                            state_next.hold = b;
                        end
                    end
                    else
                    begin
                        state_next.udp_sum = oc_add(state_reg.udp_sum, word);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRAME_CLEAR;
        end
        else if (take)
        begin
            state_reg <= item.last_byte ? FRAME_CLEAR : state_next;
        end
    end

endmodule

// File: design/ipudp_check.sv
// Frame checks in order of priority and assembly of the result item.
// Depends on ipudp_pkg.
module ipudp_check (
    input  ipudp_pkg::frame_state_t frame,
    input  logic                    skip_udp_checksum,
    output ipudp_pkg::out_item_t    result
);
    import ipudp_pkg::*;

    logic [15:0] ihl;
    logic [16:0] hdr_end;
    logic [15:0] udp_room;
    logic [15:0] csum_sum;
    logic [15:0] csum_calc;
    status_t     st;

    always_comb
    begin
        ihl       = {9'd0, frame.hdr_len};
        hdr_end   = {1'b0, ihl} + {1'b0, UDP_HDR_BYTES};
        udp_room  = frame.total_len - ihl;
        csum_sum  = oc_add(frame.udp_sum, frame.pseudo_sum);
        csum_calc = (csum_sum == CSUM_ONES) ? CSUM_ONES : ~csum_sum;

        if (frame.byte_count < MIN_HDR_BYTES)
            st = ST_SHORT;
        else if (frame.version != IP_VERSION)
            st = ST_NOT_V4;
        else if (ihl < MIN_HDR_BYTES || ihl > frame.byte_count)
            st = ST_BAD_IHL;
        else if (frame.protocol != PROTO_UDP)
            st = ST_NOT_UDP;
        else if (frame.total_len > frame.byte_count)
            st = ST_TOTAL_LONG;
        else if (frame.hdr_sum != CSUM_ONES)
            st = ST_IP_CSUM;
        else if ({1'b0, frame.total_len} < hdr_end || frame.udp_len < UDP_HDR_BYTES
                 || frame.udp_len > udp_room)
            st = ST_UDP_LEN;
        else if (!skip_udp_checksum && frame.carried_csum != 16'd0
                 && csum_calc != frame.carried_csum)
            st = ST_UDP_CSUM;
        else
            st = ST_OK;

        result        = '0;
        result.status = st;
        if (st == ST_OK)
        begin
            result.src_address    = frame.src_addr;
            result.dst_address    = frame.dst_addr;
            result.source_port    = frame.ports[31:16];
            result.dest_port      = frame.ports[15:0];
            result.payload_offset = frame.hdr_len + UDP_HDR_BYTES[6:0];
            result.payload_length = frame.udp_len - UDP_HDR_BYTES;
        end
    end

endmodule

// File: design/ipv4_udp_datagram_parser.sv
// Top level of the IPv4/UDP datagram parser: input stage, result register and handshakes.
// Depends on ipudp_pkg, ipudp_accum and ipudp_check.
//
// The frame channel carries one byte of an IPv4 frame per item, in wire order, with
// last_byte set on the final byte. The result channel carries one item per frame: a
// status code and, when the status is ok, the addresses, ports, payload offset and
// payload length. Fields other than status are zero on any error.
// An accepted byte is held in an input register and processed from there; the result of a
// frame is registered when its last byte is processed. One byte is taken in every cycle
// unless frame_stall holds a last byte; each byte passes through ones' complement adders.
// While a result waits under result_stall, bytes of the next frame keep flowing; only a
// further last byte waits in the input register, and frame_stall is raised.
// cfg_wr_en with cfg_wr_data sets skip_udp_checksum; the user must see that it is
// written only while idle, as the block itself does not enforce this.
// Reset clears all frame state, the skip flag and both valid flags.
module ipv4_udp_datagram_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    output logic                 frame_stall,
    input  ipudp_pkg::in_item_t  frame_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ipudp_pkg::out_item_t result_item,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);
    import ipudp_pkg::*;

    in_item_t     stage_item_reg;
    logic         stage_valid_reg;
    logic         skip_reg;
    logic         out_free;
    logic         stage_fire;
    frame_state_t frame_next;
    out_item_t    check_result;
    out_item_t    result_item_reg;
    logic         result_valid_reg;

    assign out_free    = !result_valid_reg || !result_stall;
    assign stage_fire  = stage_valid_reg && (!stage_item_reg.last_byte || out_free);
    assign frame_stall = stage_valid_reg && !stage_fire;

    ipudp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (stage_fire),
        .item       (stage_item_reg),
        .state_next (frame_next)
    );

    ipudp_check u_check (
        .frame             (frame_next),
        .skip_udp_checksum (skip_reg),
        .result            (check_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            skip_reg         <= 1'b0;
        end
        else
        begin
            if (!frame_stall)
            begin
                stage_valid_reg <= frame_valid;
            end
            if (stage_fire && stage_item_reg.last_byte)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                skip_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!frame_stall)
        begin
            stage_item_reg <= frame_item;
        end
        if (stage_fire && stage_item_reg.last_byte)
        begin
            result_item_reg <= check_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_on_blocked_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> stage_valid_reg && stage_item_reg.last_byte
                        && result_valid_reg && result_stall)
        else $error("input stalled without a blocked last item");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && stage_item_reg.last_byte |=> result_valid_reg)
        else $error("processed last item produced no result");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status != ST_OK |->
            result_item.src_address == 32'd0 && result_item.dst_address == 32'd0
            && result_item.source_port == 16'd0 && result_item.dest_port == 16'd0
            && result_item.payload_offset == 7'd0 && result_item.payload_length == 16'd0)
        else $error("error result carries nonzero fields");

    a_ok_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == ST_OK |->
            result_item.payload_offset >= 7'd28 && result_item.payload_offset <= 7'd68)
        else $error("ok result with impossible payload offset");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_udp_datagram_parser: directed and random IPv4/UDP frames,
// results checked field by field against an in-bench model of the parser.
// Depends on ipudp_pkg and the parser RTL only.
module tb_top;
    import ipudp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 80;
    localparam int CALM_FRAMES    = 3;

    typedef struct {
        int          ihl;
        int          pay;
        int          trail_udp;
        int          trail_frame;
        int          total_fix;
        int          udp_fix;
        bit          zero_csum;
        bit          wrap_csum;
        int          patch_pos;
        logic [7:0]  patch_xor;
        int          cut_len;
        bit          skip;
        bit          typed;
        status_t     exp_st;
    } frame_spec_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      frame_valid  = 1'b0;
    logic      frame_stall;
    in_item_t  frame_item   = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_item;
    logic      cfg_wr_en    = 1'b0;
    logic      cfg_wr_data  = 1'b0;

    logic [15:0] m_count;
    logic [6:0]  m_hlen;
    logic [3:0]  m_ver;
    logic [7:0]  m_proto;
    logic [15:0] m_total;
    logic [15:0] m_hsum;
    logic [31:0] m_src;
    logic [31:0] m_dst;
    logic [15:0] m_ulen;
    logic [15:0] m_wcs;
    logic [15:0] m_usum;
    logic [31:0] m_ports;
    logic [7:0]  m_hold;
    bit          model_skip = 1'b0;

    out_item_t   pending_verdicts[$];
    out_item_t   want_item;
    logic [7:0]  frame_bytes[$];
    frame_spec_t directed_frames[$];
    bit          use_typed;
    status_t     typed_status;
    bit          calm = 1'b0;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    int          errors       = 0;
    int          bytes_sent   = 0;
    int          frames_sent  = 0;
    int          results_seen = 0;

    ipv4_udp_datagram_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_item   (frame_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_parse_state();
        m_count = '0;
        m_hlen  = '0;
        m_ver   = '0;
        m_proto = '0;
        m_total = '0;
        m_hsum  = '0;
        m_src   = '0;
        m_dst   = '0;
        m_ulen  = '0;
        m_wcs   = '0;
        m_usum  = '0;
        m_ports = '0;
        m_hold  = '0;
    endtask

    task automatic parse_frame_byte(input logic [7:0] b, input logic l);
        int        pos;
        int        r;
        int        len;
        int        ihl;
        int        tot;
        logic [15:0] s;
        logic [15:0] cs;
        status_t   st;
        out_item_t v;
        if (m_count != BYTE_COUNT_MAX) begin
            pos = m_count;
            if (pos == 0) begin
                m_ver  = b[7:4];
                m_hlen = {1'b0, b[3:0], 2'b00};
            end else if (pos == 2) begin
                m_total = {b, 8'h00};
            end else if (pos == 3) begin
                m_total[7:0] = b;
            end else if (pos == 9) begin
                m_proto = b;
            end else if (pos >= 12 && pos < 16) begin
                m_src = {m_src[23:0], b};
            end else if (pos >= 16 && pos < 20) begin
                m_dst = {m_dst[23:0], b};
            end
            if (pos < m_hlen) begin
                if (pos % 2 == 0)
                    m_hold = b;
                else
                    m_hsum = ones_sum16(m_hsum, {m_hold, b});
            end else begin
                r = pos - m_hlen;
                if (r < 4)
                    m_ports = {m_ports[23:0], b};
                else if (r == 4)
                    m_ulen = {b, 8'h00};
                else if (r == 5)
                    m_ulen[7:0] = b;
                else if (r == 6)
                    m_wcs = {b, 8'h00};
                else if (r == 7)
                    m_wcs[7:0] = b;
                if (r < 8) begin
                    if (r % 2 == 0)
                        m_hold = b;
                    else if (r != 7)
                        m_usum = ones_sum16(m_usum, {m_hold, b});
                end else if (r < m_ulen) begin
                    if (r % 2 == 0) begin
                        if (r + 1 == m_ulen)
                            m_usum = ones_sum16(m_usum, {b, 8'h00});
                        else
                            m_hold = b;
                    end else begin
                        m_usum = ones_sum16(m_usum, {m_hold, b});
                    end
                end
            end
            m_count = m_count + 16'd1;
        end
        if (!l)
            return;

        len = m_count;
        ihl = m_hlen;
        tot = m_total;
        st  = ST_OK;
        if (len < MIN_HDR_BYTES)
            st = ST_SHORT;
        else if (m_ver != IP_VERSION)
            st = ST_NOT_V4;
        else if (ihl < MIN_HDR_BYTES || ihl > len)
            st = ST_BAD_IHL;
        else if (m_proto != PROTO_UDP)
            st = ST_NOT_UDP;
        else if (tot > len)
            st = ST_TOTAL_LONG;
        else if (m_hsum != CSUM_ONES)
            st = ST_IP_CSUM;
        else if (tot < ihl + UDP_HDR_BYTES || m_ulen < UDP_HDR_BYTES || m_ulen > tot - ihl)
            st = ST_UDP_LEN;
        else if (!model_skip && m_wcs != 16'h0000) begin
            s  = ones_sum16(m_usum, m_src[31:16]);
            s  = ones_sum16(s, m_src[15:0]);
            s  = ones_sum16(s, m_dst[31:16]);
            s  = ones_sum16(s, m_dst[15:0]);
            s  = ones_sum16(s, {8'h00, PROTO_UDP});
            s  = ones_sum16(s, m_ulen);
            cs = ~s;
            if (cs == 16'h0000)
                cs = CSUM_ONES;
            if (cs != m_wcs)
                st = ST_UDP_CSUM;
        end

        v = '0;
        v.status = st;
        if (st == ST_OK) begin
            v.src_address    = m_src;
            v.dst_address    = m_dst;
            v.source_port    = m_ports[31:16];
            v.dest_port      = m_ports[15:0];
            v.payload_offset = m_hlen + 7'd8;
            v.payload_length = m_ulen - UDP_HDR_BYTES;
        end
        if (use_typed) begin
            v = '0;
            v.status = typed_status;
        end
        pending_verdicts.push_back(v);
        clear_parse_state();
    endtask

    task automatic build_frame(input frame_spec_t s);
        int          hlen;
        int          ulen;
        int          uend;
        int          tot;
        int          n;
        int          k;
        logic [15:0] sum;
        logic [15:0] w;
        frame_bytes.delete();
        hlen = s.ihl * 4;
        ulen = (s.udp_fix >= 0) ? s.udp_fix : 8 + s.pay;
        tot  = (s.total_fix >= 0) ? s.total_fix : hlen + 8 + s.pay + s.trail_udp;
        n    = hlen + 8 + s.pay + s.trail_udp + s.trail_frame;
        for (k = 0; k < n; k++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes[0]  = {IP_VERSION, 4'(s.ihl)};
        frame_bytes[2]  = tot[15:8];
        frame_bytes[3]  = tot[7:0];
        frame_bytes[9]  = PROTO_UDP;
        frame_bytes[10] = 8'h00;
        frame_bytes[11] = 8'h00;
        sum = '0;
        for (k = 0; k < hlen; k += 2)
            sum = ones_sum16(sum, {frame_bytes[k], frame_bytes[k + 1]});
        sum = ~sum;
        frame_bytes[10] = sum[15:8];
        frame_bytes[11] = sum[7:0];

        frame_bytes[hlen + 4] = ulen[15:8];
        frame_bytes[hlen + 5] = ulen[7:0];
        frame_bytes[hlen + 6] = 8'h00;
        frame_bytes[hlen + 7] = 8'h00;
        if (s.wrap_csum && s.pay >= 2) begin
            frame_bytes[hlen + 8] = 8'h00;
            frame_bytes[hlen + 9] = 8'h00;
        end
        sum = ones_sum16(16'h0000, {frame_bytes[12], frame_bytes[13]});
        sum = ones_sum16(sum, {frame_bytes[14], frame_bytes[15]});
        sum = ones_sum16(sum, {frame_bytes[16], frame_bytes[17]});
        sum = ones_sum16(sum, {frame_bytes[18], frame_bytes[19]});
        sum = ones_sum16(sum, {8'h00, PROTO_UDP});
        sum = ones_sum16(sum, ulen[15:0]);
        uend = (hlen + ulen < n) ? hlen + ulen : n;
        for (k = hlen; k < uend; k += 2)
            sum = ones_sum16(sum, {frame_bytes[k], (k + 1 < uend) ? frame_bytes[k + 1] : 8'h00});
        if (s.wrap_csum && s.pay >= 2) begin
            // Pick the first payload word so that the computed checksum folds to zero.
            w = ~sum;
            frame_bytes[hlen + 8] = w[15:8];
            frame_bytes[hlen + 9] = w[7:0];
            sum = ones_sum16(sum, w);
        end
        sum = ~sum;
        if (sum == 16'h0000)
            sum = CSUM_ONES;
        if (s.zero_csum)
            sum = 16'h0000;
        frame_bytes[hlen + 6] = sum[15:8];
        frame_bytes[hlen + 7] = sum[7:0];

        if (s.patch_pos >= 0 && s.patch_pos < n)
            frame_bytes[s.patch_pos] = frame_bytes[s.patch_pos] ^ s.patch_xor;
        if (s.cut_len > 0 && s.cut_len < n)
            frame_bytes = frame_bytes[0:s.cut_len - 1];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_item  <= '{frame_byte: b, last_byte: l};
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        bytes_sent++;
        parse_frame_byte(b, l);
    endtask

    task automatic set_skip(input bit v);
        frame_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_skip = v;
    endtask

    task automatic send_frame(input frame_spec_t s);
        int k;
        if (s.skip != model_skip)
            set_skip(s.skip);
        build_frame(s);
        use_typed    = s.typed;
        typed_status = s.exp_st;
        for (k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    function automatic frame_spec_t random_spec(input bit clean);
        frame_spec_t s;
        int          n;
        s = '{5, 0, 0, 0, -1, -1, 1'b0, 1'b0, -1, 8'h00, 0, model_skip, 1'b0, ST_OK};
        s.pay = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            s.ihl = $urandom_range(5, 15);
        if ($urandom_range(0, 4) == 0)
            s.trail_udp = $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0)
            s.trail_frame = $urandom_range(0, 3);
        s.zero_csum = ($urandom_range(0, 9) == 0);
        s.wrap_csum = ($urandom_range(0, 11) == 0);
        n = s.ihl * 4 + 8 + s.pay + s.trail_udp + s.trail_frame;
        if (!clean) begin
            case ($urandom_range(0, 9))
                0: begin
                    s.patch_pos = $urandom_range(0, n - 1);
                    s.patch_xor = 8'($urandom_range(1, 255));
                end
                1: s.cut_len = $urandom_range(1, n - 1);
                2: s.udp_fix = $urandom_range(0, 8 + s.pay + s.trail_udp + 2);
                3: s.total_fix = $urandom_range(0, n + 2);
                default: ;
            endcase
        end
        return s;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with none expected: %p", $time, result_item);
                end else begin
                    want_item = pending_verdicts.pop_front();
                    compare_field("status", want_item.status, result_item.status);
                    compare_field("src_address", want_item.src_address,
                                  result_item.src_address);
                    compare_field("dst_address", want_item.dst_address,
                                  result_item.dst_address);
                    compare_field("source_port", want_item.source_port,
                                  result_item.source_port);
                    compare_field("dest_port", want_item.dest_port, result_item.dest_port);
                    compare_field("payload_offset", want_item.payload_offset,
                                  result_item.payload_offset);
                    compare_field("payload_length", want_item.payload_length,
                                  result_item.payload_length);
                end
            end
            if (stall_left > 0) begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(0, 10);
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles at %0t ns", idle_cycles, $time);
                $display("** ipv4_udp_datagram_parser: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int random_start;
        clear_parse_state();
        // Columns: ihl, payload, trailing inside total, trailing after total, total override,
        // UDP length override, zero checksum, wrapping checksum, patched byte, xor mask,
        // cut length, skip flag, typed expectation, expected status.
        directed_frames = '{
            '{5, 0,     0, 0, -1, -1, 0, 0, -1, 8'h00, 1,  0, 1, ST_SHORT},
            '{5, 0,     0, 0, -1, -1, 0, 0, -1, 8'h00, 19, 0, 1, ST_SHORT},
            '{5, 0,     0, 0, -1, -1, 0, 0, -1, 8'h00, 20, 0, 1, ST_TOTAL_LONG},
            '{5, 0,     0, 0, -1, -1, 0, 0, -1, 8'h00, 0,  0, 0, ST_OK},
            '{5, 4,     0, 0, -1, -1, 0, 0, 0,  8'h20, 0,  0, 1, ST_NOT_V4},
            '{5, 4,     0, 0, -1, -1, 0, 0, 0,  8'h01, 0,  0, 1, ST_BAD_IHL},
            '{5, 4,     0, 0, -1, -1, 0, 0, 0,  8'h0a, 0,  0, 1, ST_BAD_IHL},
            '{5, 4,     0, 0, -1, -1, 0, 0, 0,  8'h05, 0,  0, 1, ST_BAD_IHL},
            '{5, 4,     0, 0, -1, -1, 0, 0, 9,  8'h17, 0,  0, 1, ST_NOT_UDP},
            '{5, 4,     0, 0, -1, -1, 0, 0, 2,  8'hff, 0,  0, 1, ST_TOTAL_LONG},
            '{5, 4,     0, 0, -1, -1, 0, 0, 8,  8'h01, 0,  0, 1, ST_IP_CSUM},
            '{5, 0,     0, 0, 24, -1, 0, 0, -1, 8'h00, 0,  0, 1, ST_UDP_LEN},
            '{5, 4,     0, 0, -1, 4,  0, 0, -1, 8'h00, 0,  0, 1, ST_UDP_LEN},
            '{5, 0,     0, 0, -1, 9,  0, 0, -1, 8'h00, 0,  0, 1, ST_UDP_LEN},
            '{5, 6,     0, 0, -1, -1, 0, 0, 28, 8'h01, 0,  0, 1, ST_UDP_CSUM},
            '{5, 6,     0, 0, -1, -1, 1, 0, 28, 8'h01, 0,  0, 0, ST_OK},
            '{5, 5,     0, 0, -1, -1, 0, 0, -1, 8'h00, 0,  0, 0, ST_OK},
            '{5, 7,     3, 2, -1, -1, 0, 0, -1, 8'h00, 0,  0, 0, ST_OK},
            '{15, 3,    0, 0, -1, -1, 0, 0, -1, 8'h00, 0,  0, 0, ST_OK},
            '{5, 10,    0, 0, -1, -1, 0, 1, -1, 8'h00, 0,  0, 0, ST_OK},
            '{5, 6,     0, 0, -1, -1, 0, 0, 28, 8'h01, 0,  1, 0, ST_OK},
            '{5, 0,     0, 0, -1, -1, 0, 0, -1, 8'h00, 0,  1, 0, ST_OK}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_skip(1'b0);

        foreach (directed_frames[k])
            send_frame(directed_frames[k]);

        random_start = bytes_sent;
        k = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (k % 8 == 7)
                set_skip(1'($urandom_range(0, 1)));
            send_frame(random_spec(1'b0));
            k++;
        end

        calm = 1'b1;
        for (k = 0; k < CALM_FRAMES; k++)
            send_frame(random_spec(1'b1));
        frame_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d frames (%0d bytes) and checked %0d results, every status code,",
                 frames_sent, bytes_sent, results_seen);
        $display("UDP checksum checking on and off, odd and padded lengths and random stalls.");
        if (errors == 0)
            $display("** ipv4_udp_datagram_parser: PASSED **");
        else
            $display("** ipv4_udp_datagram_parser: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/ipudp_pkg.sv
design/ipudp_accum.sv
design/ipudp_check.sv
design/ipv4_udp_datagram_parser.sv
verif/tb_top.sv
